FILE: rtl/lsqf_pkg.sv
// Shared types, widths and codes for the least-squares line fit block.
package lsqf_pkg;

    localparam int COORD_W  = 16;
    localparam int COUNT_W  = 13;
    localparam int SUM_W    = 29;
    localparam int PROD_W   = 32;
    localparam int SQ_W     = 43;
    localparam int OUT_W    = 48;
    localparam int STATUS_W = 2;

    // Shared multiplier: signed multiplicand times signed multiplier.
    localparam int MCAND_W  = SQ_W;
    localparam int MPLIER_W = SUM_W;
    // Products and the fit numerators and denominator are held in this width.
    localparam int ACC_W    = 72;
    // A positive denominator is below 2^55 for any legal point count.
    localparam int DEN_W    = 56;

    localparam int QUEUE_DEPTH = 2;

    localparam int MAX_POINTS_DEF = 4096;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [OUT_W-1:0] OUT_POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [STATUS_W-1:0] {
        FS_OK        = 2'd0,
        FS_ZERO_DEN  = 2'd1,
        FS_SATURATED = 2'd2,
        FS_TOO_MANY  = 2'd3
    } fit_status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_value;
        logic signed [COORD_W-1:0] y_value;
        logic                      last_point;
    } point_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] intercept_a;
        logic signed [OUT_W-1:0] slope_b;
        logic [COUNT_W-1:0]      point_count;
        fit_status_t             fit_status;
    } fit_t;

    // Sums of one finished point set, handed from the front to the back.
    typedef struct packed {
        logic [COUNT_W-1:0]      count;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SQ_W-1:0]  sum_xy;
        logic signed [SQ_W-1:0]  sum_xx;
        logic                    overflow;
    } snap_t;

    typedef struct packed {
        logic                       start;
        logic signed [MCAND_W-1:0]  mcand;
        logic signed [MPLIER_W-1:0] mplier;
    } mul_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [OUT_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        MS_N_SXX,
        MS_SX_SX,
        MS_N_SXY,
        MS_SX_SY,
        MS_SXX_SY,
        MS_SX_SXY
    } mul_step_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_START,
        BK_MUL_WAIT,
        BK_CHECK,
        BK_DIV_B,
        BK_DIV_A,
        BK_EMIT
    } back_state_t;

endpackage

FILE: rtl/lsqf_mul.sv
// Sequential shift-and-add signed multiplier, one multiplier bit per cycle.
module lsqf_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  lsqf_pkg::mul_req_t req,
    output lsqf_pkg::mul_rsp_t rsp
);

    localparam int MCAND_W  = lsqf_pkg::MCAND_W;
    localparam int MPLIER_W = lsqf_pkg::MPLIER_W;
    localparam int ACC_W    = lsqf_pkg::ACC_W;
    localparam int CNT_W    = $clog2(MPLIER_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    mcand_reg, mcand_next;
    logic [MPLIER_W-1:0] mplier_reg, mplier_next;
    logic [ACC_W-1:0]    product_reg, product_next;
    logic [MCAND_W-1:0]  mcand_mag;
    logic [MPLIER_W-1:0] mplier_mag;

    always_comb
    begin
        mcand_mag  = req.mcand[MCAND_W-1] ? (~req.mcand + MCAND_W'(1)) : req.mcand;
        mplier_mag = req.mplier[MPLIER_W-1] ? (~req.mplier + MPLIER_W'(1)) : req.mplier;

        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        product_next = product_reg;

        if (req.start)
        begin
            busy_next   = 1'b1;
            cnt_next    = CNT_W'(MPLIER_W);
            neg_next    = req.mcand[MCAND_W-1] ^ req.mplier[MPLIER_W-1];
            acc_next    = '0;
            mcand_next  = ACC_W'(mcand_mag);
            mplier_next = mplier_mag;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - CNT_W'(1);
        end
        else if (busy_reg)
        begin
            // All multiplier bits are done; apply the sign of the product.
            product_next = neg_reg ? (~acc_reg + ACC_W'(1)) : acc_reg;
            busy_next    = 1'b0;
            done_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        product_reg <= product_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = product_reg;

endmodule

FILE: rtl/lsqf_div.sv
// Restoring fixed-point divider, one quotient bit per cycle, saturating to 48 bits.
module lsqf_div #(
    parameter int FRAC_BITS = lsqf_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lsqf_pkg::div_req_t req,
    output lsqf_pkg::div_rsp_t rsp
);

    localparam int ACC_W  = lsqf_pkg::ACC_W;
    localparam int DEN_W  = lsqf_pkg::DEN_W;
    localparam int OUT_W  = lsqf_pkg::OUT_W;
    localparam int DIVD_W = ACC_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(DIVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [DIVD_W-1:0] dvd_reg, dvd_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [OUT_W-1:0]  quo_reg, quo_next;
    logic              hi_reg, hi_next;
    logic [OUT_W-1:0]  result_reg, result_next;
    logic              sat_reg, sat_next;
    logic [ACC_W-1:0]  num_mag;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_diff;
    logic              fits;
    logic              over;
    logic [OUT_W-1:0]  mag;

    always_comb
    begin
        num_mag    = req.num[ACC_W-1] ? (~req.num + ACC_W'(1)) : req.num;
        trial      = {rem_reg, dvd_reg[DIVD_W-1]};
        trial_diff = trial - {1'b0, den_reg};
        fits       = (trial >= {1'b0, den_reg});

        // Quotient bits above the low 48 are only kept as a sticky flag.
        if (neg_reg)
        begin
            over = hi_reg || (quo_reg[OUT_W-1] && (quo_reg[OUT_W-2:0] != '0));
        end
        else
        begin
            over = hi_reg || quo_reg[OUT_W-1];
        end
        if (over)
        begin
            mag = neg_reg ? lsqf_pkg::OUT_NEG_LIMIT : lsqf_pkg::OUT_POS_LIMIT;
        end
        else
        begin
            mag = quo_reg;
        end

        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        hi_next     = hi_reg;
        result_next = result_reg;
        sat_next    = sat_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVD_W);
            neg_next  = req.num[ACC_W-1];
            dvd_next  = DIVD_W'(num_mag) << FRAC_BITS;
            rem_next  = '0;
            den_next  = req.den;
            quo_next  = '0;
            hi_next   = 1'b0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_next = fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[OUT_W-2:0], fits};
            hi_next  = hi_reg || quo_reg[OUT_W-1];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else if (busy_reg)
        begin
            result_next = neg_reg ? (~mag + OUT_W'(1)) : mag;
            sat_next    = over;
            busy_next   = 1'b0;
            done_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        hi_reg     <= hi_next;
        result_reg <= result_next;
        sat_reg    <= sat_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.sat      = sat_reg;
    assign rsp.quotient = result_reg;

endmodule

FILE: rtl/lsqf_front.sv
// Front end: takes points, forms the products and keeps the running sums.
module lsqf_front #(
    parameter int MAX_POINTS = lsqf_pkg::MAX_POINTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    output logic             point_stall,
    input  lsqf_pkg::point_t point,
    input  logic             queue_full,
    output logic             push,
    output lsqf_pkg::snap_t  snap
);

    localparam int COORD_W = lsqf_pkg::COORD_W;
    localparam int COUNT_W = lsqf_pkg::COUNT_W;
    localparam int SUM_W   = lsqf_pkg::SUM_W;
    localparam int PROD_W  = lsqf_pkg::PROD_W;
    localparam int SQ_W    = lsqf_pkg::SQ_W;

    logic                      a_valid_reg, a_valid_next;
    logic                      a_last_reg;
    logic signed [COORD_W-1:0] a_x_reg;
    logic signed [COORD_W-1:0] a_y_reg;
    logic signed [PROD_W-1:0]  a_xy_reg;
    logic signed [PROD_W-1:0]  a_xx_reg;

    logic [COUNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0]   sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]   sum_y_reg, sum_y_next;
    logic signed [SQ_W-1:0]    sum_xy_reg, sum_xy_next;
    logic signed [SQ_W-1:0]    sum_xx_reg, sum_xx_next;
    logic                      ovf_reg, ovf_next;

    logic accept;
    logic advance;
    logic can_add;

    always_comb
    begin
        // Only a last point waiting on a full queue holds the front up.
        point_stall = a_valid_reg && a_last_reg && queue_full;
        accept      = point_valid && !point_stall;
        advance     = a_valid_reg && !point_stall;
        can_add     = (count_reg < COUNT_W'(MAX_POINTS));
        push        = advance && a_last_reg;

        if (can_add)
        begin
            snap.count  = count_reg + COUNT_W'(1);
            snap.sum_x  = sum_x_reg + SUM_W'(a_x_reg);
            snap.sum_y  = sum_y_reg + SUM_W'(a_y_reg);
            snap.sum_xy = sum_xy_reg + SQ_W'(a_xy_reg);
            snap.sum_xx = sum_xx_reg + SQ_W'(a_xx_reg);
        end
        else
        begin
            snap.count  = count_reg;
            snap.sum_x  = sum_x_reg;
            snap.sum_y  = sum_y_reg;
            snap.sum_xy = sum_xy_reg;
            snap.sum_xx = sum_xx_reg;
        end
        snap.overflow = ovf_reg || !can_add;

        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (advance)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end

        count_next  = count_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        sum_xy_next = sum_xy_reg;
        sum_xx_next = sum_xx_reg;
        ovf_next    = ovf_reg;
        if (advance && a_last_reg)
        begin
            count_next  = '0;
            sum_x_next  = '0;
            sum_y_next  = '0;
            sum_xy_next = '0;
            sum_xx_next = '0;
            ovf_next    = 1'b0;
        end
        else if (advance)
        begin
            count_next  = snap.count;
            sum_x_next  = snap.sum_x;
            sum_y_next  = snap.sum_y;
            sum_xy_next = snap.sum_xy;
            sum_xx_next = snap.sum_xx;
            ovf_next    = snap.overflow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            count_reg   <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            sum_xy_reg  <= '0;
            sum_xx_reg  <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            count_reg   <= count_next;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            sum_xy_reg  <= sum_xy_next;
            sum_xx_reg  <= sum_xx_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_last_reg <= point.last_point;
            a_x_reg    <= point.x_value;
            a_y_reg    <= point.y_value;
            a_xy_reg   <= point.x_value * point.y_value;
            a_xx_reg   <= point.x_value * point.x_value;
        end
    end

endmodule

FILE: rtl/lsqf_fifo.sv
// Short queue of finished point-set sums between the front and the back.
module lsqf_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lsqf_pkg::snap_t wr_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output lsqf_pkg::snap_t rd_data
);

    localparam int DEPTH = lsqf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lsqf_pkg::snap_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    always_comb
    begin
        full  = (fill_reg == CNT_W'(DEPTH));
        empty = (fill_reg == '0);

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = entry_reg[rd_ptr_reg];

endmodule

FILE: rtl/lsqf_back.sv
// Back end: sequences the six products and two divisions of one fit and holds the result.
module lsqf_back #(
    parameter int FRAC_BITS = lsqf_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            queue_empty,
    input  lsqf_pkg::snap_t queue_data,
    output logic            pop,
    output logic            fit_valid,
    input  logic            fit_stall,
    output lsqf_pkg::fit_t  fit
);

    localparam int ACC_W    = lsqf_pkg::ACC_W;
    localparam int DEN_W    = lsqf_pkg::DEN_W;
    localparam int OUT_W    = lsqf_pkg::OUT_W;
    localparam int MCAND_W  = lsqf_pkg::MCAND_W;
    localparam int MPLIER_W = lsqf_pkg::MPLIER_W;

    lsqf_pkg::back_state_t   state_reg, state_next;
    lsqf_pkg::mul_step_t     step_reg, step_next;
    lsqf_pkg::snap_t         snap_reg, snap_next;
    logic signed [ACC_W-1:0] den_reg, den_next;
    logic signed [ACC_W-1:0] numb_reg, numb_next;
    logic signed [ACC_W-1:0] numa_reg, numa_next;
    logic [OUT_W-1:0]        slope_reg, slope_next;
    logic [OUT_W-1:0]        icpt_reg, icpt_next;
    logic                    sat_reg, sat_next;
    lsqf_pkg::fit_status_t   status_reg, status_next;
    logic                    fit_valid_reg, fit_valid_next;
    lsqf_pkg::fit_t          fit_reg, fit_next;

    lsqf_pkg::mul_req_t mul_req;
    lsqf_pkg::mul_rsp_t mul_rsp;
    lsqf_pkg::div_req_t div_req;
    lsqf_pkg::div_rsp_t div_rsp;

    lsqf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    lsqf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        snap_next      = snap_reg;
        den_next       = den_reg;
        numb_next      = numb_reg;
        numa_next      = numa_reg;
        slope_next     = slope_reg;
        icpt_next      = icpt_reg;
        sat_next       = sat_reg;
        status_next    = status_reg;
        fit_valid_next = fit_valid_reg && fit_stall;
        fit_next       = fit_reg;
        pop            = 1'b0;

        mul_req.start = 1'b0;
        unique case (step_reg)
            lsqf_pkg::MS_N_SXX:
            begin
                mul_req.mcand  = snap_reg.sum_xx;
                mul_req.mplier = MPLIER_W'(snap_reg.count);
            end
            lsqf_pkg::MS_SX_SX:
            begin
                mul_req.mcand  = MCAND_W'(snap_reg.sum_x);
                mul_req.mplier = snap_reg.sum_x;
            end
            lsqf_pkg::MS_N_SXY:
            begin
                mul_req.mcand  = snap_reg.sum_xy;
                mul_req.mplier = MPLIER_W'(snap_reg.count);
            end
            lsqf_pkg::MS_SX_SY:
            begin
                mul_req.mcand  = MCAND_W'(snap_reg.sum_y);
                mul_req.mplier = snap_reg.sum_x;
            end
            lsqf_pkg::MS_SXX_SY:
            begin
                mul_req.mcand  = snap_reg.sum_xx;
                mul_req.mplier = snap_reg.sum_y;
            end
            lsqf_pkg::MS_SX_SXY:
            begin
                mul_req.mcand  = snap_reg.sum_xy;
                mul_req.mplier = snap_reg.sum_x;
            end
            default:
            begin
                mul_req.mcand  = '0;
                mul_req.mplier = '0;
            end
        endcase

        div_req.start = 1'b0;
        div_req.num   = (state_reg == lsqf_pkg::BK_DIV_B) ? numa_reg : numb_reg;
        div_req.den   = den_reg[DEN_W-1:0];

        unique case (state_reg)
            lsqf_pkg::BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    snap_next  = queue_data;
                    step_next  = lsqf_pkg::MS_N_SXX;
                    state_next = lsqf_pkg::BK_MUL_START;
                end
            end
            lsqf_pkg::BK_MUL_START:
            begin
                mul_req.start = 1'b1;
                state_next    = lsqf_pkg::BK_MUL_WAIT;
            end
            lsqf_pkg::BK_MUL_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = lsqf_pkg::BK_MUL_START;
                    unique case (step_reg)
                        lsqf_pkg::MS_N_SXX:
                        begin
                            den_next  = mul_rsp.product;
                            step_next = lsqf_pkg::MS_SX_SX;
                        end
                        lsqf_pkg::MS_SX_SX:
                        begin
                            den_next  = den_reg - mul_rsp.product;
                            step_next = lsqf_pkg::MS_N_SXY;
                        end
                        lsqf_pkg::MS_N_SXY:
                        begin
                            numb_next = mul_rsp.product;
                            step_next = lsqf_pkg::MS_SX_SY;
                        end
                        lsqf_pkg::MS_SX_SY:
                        begin
                            numb_next = numb_reg - mul_rsp.product;
                            step_next = lsqf_pkg::MS_SXX_SY;
                        end
                        lsqf_pkg::MS_SXX_SY:
                        begin
                            numa_next = mul_rsp.product;
                            step_next = lsqf_pkg::MS_SX_SXY;
                        end
                        lsqf_pkg::MS_SX_SXY:
                        begin
                            numa_next  = numa_reg - mul_rsp.product;
                            state_next = lsqf_pkg::BK_CHECK;
                        end
                        default:
                        begin
                            state_next = lsqf_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            lsqf_pkg::BK_CHECK:
            begin
                // A denominator of zero or below means fewer than two points or all x equal.
                if (den_reg[ACC_W-1] || (den_reg == '0))
                begin
                    slope_next  = '0;
                    icpt_next   = '0;
                    status_next = lsqf_pkg::FS_ZERO_DEN;
                    state_next  = lsqf_pkg::BK_EMIT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    sat_next      = 1'b0;
                    state_next    = lsqf_pkg::BK_DIV_B;
                end
            end
            lsqf_pkg::BK_DIV_B:
            begin
                if (div_rsp.done)
                begin
                    slope_next    = div_rsp.quotient;
                    sat_next      = div_rsp.sat;
                    div_req.start = 1'b1;
                    state_next    = lsqf_pkg::BK_DIV_A;
                end
            end
            lsqf_pkg::BK_DIV_A:
            begin
                if (div_rsp.done)
                begin
                    icpt_next = div_rsp.quotient;
                    priority if (snap_reg.overflow)
                    begin
                        status_next = lsqf_pkg::FS_TOO_MANY;
                    end
                    else if (sat_reg || div_rsp.sat)
                    begin
                        status_next = lsqf_pkg::FS_SATURATED;
                    end
                    else
                    begin
                        status_next = lsqf_pkg::FS_OK;
                    end
                    state_next = lsqf_pkg::BK_EMIT;
                end
            end
            lsqf_pkg::BK_EMIT:
            begin
                if (!fit_valid_reg || !fit_stall)
                begin
                    fit_next.intercept_a = icpt_reg;
                    fit_next.slope_b     = slope_reg;
                    fit_next.point_count = snap_reg.count;
                    fit_next.fit_status  = status_reg;
                    fit_valid_next       = 1'b1;
                    state_next           = lsqf_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lsqf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsqf_pkg::BK_IDLE;
            step_reg      <= lsqf_pkg::MS_N_SXX;
            fit_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            fit_valid_reg <= fit_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg   <= snap_next;
        den_reg    <= den_next;
        numb_reg   <= numb_next;
        numa_reg   <= numa_next;
        slope_reg  <= slope_next;
        icpt_reg   <= icpt_next;
        sat_reg    <= sat_next;
        status_reg <= status_next;
        fit_reg    <= fit_next;
    end

    assign fit_valid = fit_valid_reg;
    assign fit       = fit_reg;

endmodule

FILE: rtl/least_squares_line_fit.sv
// Least-squares straight-line fit over sets of signed 16-bit points.
//
// The point channel (point_valid, point_stall, point) takes one item per cycle while point_stall is low.
// Each item adds x, y, x*y and x*x to running sums; the item flagged last_point
// closes the set, whose sums move into a two-entry queue while the sums clear.
// The fit channel (fit_valid, fit_stall, fit) then returns one item per set:
// intercept and slope in signed Q(47-FRAC_BITS).FRAC_BITS, truncated toward zero
// and saturated, with the point count and a status code.
// Points beyond MAX_POINTS in a set are dropped and reported as too many points.
// The front takes points back to back; it stalls only when a last point finds
// the queue full. The back end works through one set at a time, with the
// bit-serial multiplier and the one-bit-per-cycle divider; an accepted last
// point's sums pass through the queue, the six products, the two divisions
// and the output register before its fit item is shown on the fit channel.
// A stalled fit item holds in the output register while the back end fetches
// and computes the next set. Reset clears the sums, the queue and the output.
module least_squares_line_fit #(
    parameter int MAX_POINTS = lsqf_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = lsqf_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    output logic             point_stall,
    input  lsqf_pkg::point_t point,
    output logic             fit_valid,
    input  logic             fit_stall,
    output lsqf_pkg::fit_t   fit
);

    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_empty;
    lsqf_pkg::snap_t push_data;
    lsqf_pkg::snap_t pop_data;

    lsqf_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .queue_full  (queue_full),
        .push        (push),
        .snap        (push_data)
    );

    lsqf_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_data),
        .full    (queue_full),
        .pop     (pop),
        .empty   (queue_empty),
        .rd_data (pop_data)
    );

    lsqf_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_data  (pop_data),
        .pop         (pop),
        .fit_valid   (fit_valid),
        .fit_stall   (fit_stall),
        .fit         (fit)
    );

endmodule

FILE: rtl/lsqf_checker.sv
// Port-level checks on the fit channel of the line fit block, with its bind.
module lsqf_checker #(
    parameter int MAX_POINTS = lsqf_pkg::MAX_POINTS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    input logic           fit_valid,
    input logic           fit_stall,
    input lsqf_pkg::fit_t fit
);

    localparam int COUNT_W = lsqf_pkg::COUNT_W;
    localparam logic [COUNT_W-1:0] CAP       = COUNT_W'(MAX_POINTS);
    localparam logic [COUNT_W-1:0] MIN_SPAN  = COUNT_W'(2);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fit_valid && fit_stall |=> fit_valid)
        else $error("fit item dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fit_valid && fit_stall |=> $stable(fit))
        else $error("fit item changed while stalled");

    a_zero_den_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fit_valid && (fit.fit_status == lsqf_pkg::FS_ZERO_DEN)
        |-> (fit.intercept_a == '0) && (fit.slope_b == '0))
        else $error("zero denominator item carries a nonzero result");

    a_too_many_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fit_valid && (fit.fit_status == lsqf_pkg::FS_TOO_MANY)
        |-> (fit.point_count == CAP))
        else $error("too many points reported below the capacity");

    a_fit_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        fit_valid && (fit.fit_status != lsqf_pkg::FS_ZERO_DEN)
        |-> (fit.point_count >= MIN_SPAN))
        else $error("fit computed from fewer than two points");

endmodule

bind least_squares_line_fit lsqf_checker #(
    .MAX_POINTS (MAX_POINTS)
) u_lsqf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .fit_valid (fit_valid),
    .fit_stall (fit_stall),
    .fit       (fit)
);
